>>> sv/bdv_pkg.sv
// ----------------------------------------------------------------------------
// bdv_pkg
// Types, constants and helper functions for the BCD date validator.
// ----------------------------------------------------------------------------
package bdv_pkg;

  typedef logic [7:0] bcd_byte_t;   // two BCD digits, tens in the high nibble
  typedef logic [3:0] nibble_t;
  typedef logic [3:0] month_bin_t;  // 1..12 once checked
  typedef logic [5:0] day_bin_t;    // up to 39 after the tens check

  localparam nibble_t    DIGIT_MAX       = 4'd9;
  localparam nibble_t    MONTH_TENS_MAX  = 4'd1;
  localparam nibble_t    DAY_TENS_MAX    = 4'd3;
  localparam month_bin_t MONTH_LAST      = 4'd12;
  localparam month_bin_t MONTH_FEB       = 4'd2;
  localparam month_bin_t MONTH_APR       = 4'd4;
  localparam month_bin_t MONTH_JUN       = 4'd6;
  localparam month_bin_t MONTH_SEP       = 4'd9;
  localparam month_bin_t MONTH_NOV       = 4'd11;
  localparam day_bin_t   DAYS_LONG       = 6'd31;
  localparam day_bin_t   DAYS_SHORT      = 6'd30;
  localparam day_bin_t   DAYS_FEB        = 6'd28;
  localparam day_bin_t   DAYS_FEB_LEAP   = 6'd29;

  // Both nibbles within their limits.
  function automatic logic digits_ok(input bcd_byte_t b, input nibble_t tens_max);
    return (b[7:4] <= tens_max) && (b[3:0] <= DIGIT_MAX);
  endfunction

  // Two-digit BCD value divisible by four: 10t+u = 2t+u (mod 4).
  function automatic logic bcd_div4(input bcd_byte_t b);
    logic even_tens;
    even_tens = ~b[4];
    if (even_tens) begin
      return (b[3:0] == 4'd0) || (b[3:0] == 4'd4) || (b[3:0] == 4'd8);
    end
    return (b[3:0] == 4'd2) || (b[3:0] == 4'd6);
  endfunction

  // Gregorian leap rule on a four-digit BCD year. A year ending in 00 is a
  // leap year only when its century is divisible by four.
  function automatic logic bcd_leap(input bcd_byte_t yh, input bcd_byte_t yl);
    if (yl == 8'h00) begin
      return bcd_div4(yh);
    end
    return bcd_div4(yl);
  endfunction

  function automatic day_bin_t month_days(input month_bin_t m, input logic leap);
    day_bin_t d;
    case (m) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = DAYS_SHORT;
      MONTH_FEB:                                  d = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      default:                                    d = DAYS_LONG;
    endcase
    return d;
  endfunction

endpackage

>>> sv/bcd_date_validator_unit.sv
// ----------------------------------------------------------------------------
// bcd_date_validator_unit
// Checks a packed BCD calendar date and flags whether it is well formed.
// ----------------------------------------------------------------------------
// Two-stage pipeline: the item is captured in an input register, checked by
// short combinational logic and its flag captured in the output register.
// One item per cycle is sustained while out_ready stays high. Ready is passed back
// combinationally from out_ready to in_ready, so a stalled result holds the
// stages behind it. No configuration and no state beyond the pipeline.
module bcd_date_validator_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdv_pkg::bcd_byte_t in_year_high_bcd,
  input  bdv_pkg::bcd_byte_t in_year_low_bcd,
  input  bdv_pkg::bcd_byte_t in_month_bcd,
  input  bdv_pkg::bcd_byte_t in_day_bcd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_date_valid
);
  import bdv_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  bcd_byte_t yh_r, yl_r, mb_r, db_r;
  logic      out_valid_r, out_valid_nxt;
  logic      date_valid_r;

  logic       out_load;
  logic       s1_load;
  month_bin_t month_bin;
  day_bin_t   day_bin;
  logic       leap;
  logic       fmt_ok;
  logic       month_ok;
  logic       day_ok;
  logic       check_ok;

  // Handshake
  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;
  assign s1_load  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Check
  assign fmt_ok    = digits_ok(yh_r, DIGIT_MAX) && digits_ok(yl_r, DIGIT_MAX) &&
                     digits_ok(mb_r, MONTH_TENS_MAX) && digits_ok(db_r, DAY_TENS_MAX);
  // tens digit of month is 0 or 1 once fmt_ok holds
  assign month_bin = mb_r[4] ? (mb_r[3:0] + 4'd10) : mb_r[3:0];
  assign day_bin   = ({2'b00, db_r[7:4]} << 3) + ({2'b00, db_r[7:4]} << 1) +
                     {2'b00, db_r[3:0]};
  assign leap      = bcd_leap(yh_r, yl_r);
  // with a tens digit of one only units up to two make a month; month_bin wraps above
  assign month_ok  = (month_bin != 4'd0) && (month_bin <= MONTH_LAST) && (mb_r[7:5] == 3'd0) &&
                     (!mb_r[4] || (mb_r[3:0] <= 4'd2));
  assign day_ok    = (day_bin != 6'd0) && (day_bin <= month_days(month_bin, leap));
  assign check_ok  = fmt_ok && month_ok && day_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      yh_r <= in_year_high_bcd;
      yl_r <= in_year_low_bcd;
      mb_r <= in_month_bcd;
      db_r <= in_day_bcd;
    end
    if (out_load) begin
      date_valid_r <= check_ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_date_valid = date_valid_r;

  // A checked item always lands in the output register.
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("checked item not presented at output");

  // Input may only be taken when stage one has room.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |-> (!s1_valid_r || out_load))
    else $error("item accepted over an occupied stage");

  // A bad month never yields a valid flag.
  a_bad_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (month_bin == 4'd0 || month_bin > MONTH_LAST)) |=> !date_valid_r)
    else $error("invalid month flagged as valid");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

>>> tb/sv/bcd_date_validator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_date_validator_unit_tb
// Self-checking bench for the BCD calendar date checker.
// ----------------------------------------------------------------------------
// Dates are queued up front: a directed set covering digit, month, day and
// leap-rule corners, then random dates that are mostly well formed, with bad
// digits and junk bytes mixed in. A driver feeds them with random gaps and a
// monitor takes results with random stalls. Each result is compared with the
// flag predicted for the oldest outstanding date.
// ----------------------------------------------------------------------------
module bcd_date_validator_unit_tb;
  import bdv_pkg::*;

  localparam int RANDOM_DATES  = 1400;
  localparam int WAIT_MAX      = 12;
  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    bcd_byte_t yh;
    bcd_byte_t yl;
    bcd_byte_t mb;
    bcd_byte_t db;
  } date_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  bcd_byte_t in_year_high_bcd = '0;
  bcd_byte_t in_year_low_bcd = '0;
  bcd_byte_t in_month_bcd = '0;
  bcd_byte_t in_day_bcd = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      out_date_valid;

  date_item_t pending_dates[$];
  bit         expected_flags[$];
  int         dates_total;
  int         dates_sent;
  int         mismatches;
  int         unexpected;
  int         send_wait;
  int         recv_stall;
  int         quiet_cycles;
  int         phase_cnt;
  bit         want_flag;

  bcd_date_validator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_year_high_bcd (in_year_high_bcd),
    .in_year_low_bcd  (in_year_low_bcd),
    .in_month_bcd     (in_month_bcd),
    .in_day_bcd       (in_day_bcd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_date_valid   (out_date_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Decimal value of a byte whose nibbles are already known to be digits.
  function automatic int unsigned bcd_to_int(input bcd_byte_t b);
    return b[7:4] * 10 + b[3:0];
  endfunction

  function automatic bcd_byte_t int_to_bcd(input int unsigned v);
    bcd_byte_t b;
    b[7:4] = 4'(v / 10);
    b[3:0] = 4'(v % 10);
    return b;
  endfunction

  function automatic bit date_exists(input date_item_t d);
    int unsigned year;
    int unsigned month;
    int unsigned day;
    int unsigned month_len;
    bit          leap;
    if (d.yh[7:4] > 9 || d.yh[3:0] > 9 || d.yl[7:4] > 9 || d.yl[3:0] > 9) return 1'b0;
    year = bcd_to_int(d.yh) * 100 + bcd_to_int(d.yl);
    if (d.mb[7:4] > 1 || d.mb[3:0] > 9) return 1'b0;
    month = bcd_to_int(d.mb);
    if (month == 0 || month > 12) return 1'b0;
    leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    if (d.db[7:4] > 3 || d.db[3:0] > 9) return 1'b0;
    day = bcd_to_int(d.db);
    case (month)
      4, 6, 9, 11: month_len = 30;
      2:           month_len = leap ? 29 : 28;
      default:     month_len = 31;
    endcase
    return (day != 0) && (day <= month_len);
  endfunction

  function automatic date_item_t make_date(input int unsigned y, input int unsigned m,
                                           input int unsigned d);
    date_item_t t;
    t.yh = int_to_bcd(y / 100);
    t.yl = int_to_bcd(y % 100);
    t.mb = int_to_bcd(m);
    t.db = int_to_bcd(d);
    return t;
  endfunction

  function automatic date_item_t random_date();
    date_item_t  t;
    int unsigned kind;
    int unsigned m;
    int unsigned d;
    kind = $urandom_range(0, 99);
    t.yh = int_to_bcd($urandom_range(0, 99));
    t.yl = ($urandom_range(0, 7) == 0) ? 8'h00 : int_to_bcd($urandom_range(0, 99));
    m    = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
    // lean towards the month end, where the length table matters
    d    = ($urandom_range(0, 1) == 0) ? $urandom_range(27, 31) : $urandom_range(1, 31);
    t.mb = int_to_bcd(m);
    t.db = int_to_bcd(d);
    if (kind >= 90) begin
      t = date_item_t'($urandom());
    end else if (kind >= 80) begin
      // one byte of the date replaced by junk
      case ($urandom_range(0, 3))
        0:       t.yh = 8'($urandom());
        1:       t.yl = 8'($urandom());
        2:       t.mb = 8'($urandom());
        default: t.db = 8'($urandom());
      endcase
    end else if (kind >= 75) begin
      t.mb = int_to_bcd($urandom_range(0, 19));
      t.db = int_to_bcd($urandom_range(0, 39));
    end
    return t;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, WAIT_MAX));
  endfunction

  // Stimulus, then end of run
  initial begin
    pending_dates.push_back(make_date(2000, 2, 29));  // century divisible by 400
    pending_dates.push_back(make_date(1900, 2, 29));  // century not leap
    pending_dates.push_back(make_date(2100, 2, 29));
    pending_dates.push_back(make_date(2400, 2, 29));
    pending_dates.push_back(make_date(2024, 2, 29));
    pending_dates.push_back(make_date(2023, 2, 29));
    pending_dates.push_back(make_date(2023, 2, 28));
    pending_dates.push_back(make_date(0, 2, 29));     // year zero is leap
    pending_dates.push_back(make_date(9999, 12, 31));
    pending_dates.push_back(make_date(1, 1, 1));
    pending_dates.push_back(make_date(2021, 4, 31));  // past end of short month
    pending_dates.push_back(make_date(2021, 4, 30));
    pending_dates.push_back(make_date(2021, 0, 10));  // month zero
    pending_dates.push_back(make_date(2021, 13, 10)); // month above twelve
    pending_dates.push_back(date_item_t'{8'h20, 8'h21, 8'h20, 8'h10});  // month tens above one
    pending_dates.push_back(date_item_t'{8'h20, 8'h21, 8'h1A, 8'h10});  // bad month units
    pending_dates.push_back(date_item_t'{8'h20, 8'h21, 8'h17, 8'h10});  // month seventeen
    pending_dates.push_back(make_date(2021, 5, 0));   // day zero
    pending_dates.push_back(date_item_t'{8'h20, 8'h21, 8'h05, 8'h40});  // day tens above three
    pending_dates.push_back(date_item_t'{8'h20, 8'h21, 8'h05, 8'h3A});  // bad day units
    pending_dates.push_back(date_item_t'{8'hA0, 8'h21, 8'h05, 8'h10});  // bad thousands digit
    pending_dates.push_back(date_item_t'{8'h2F, 8'h21, 8'h05, 8'h10});
    pending_dates.push_back(date_item_t'{8'h20, 8'hF1, 8'h05, 8'h10});
    pending_dates.push_back(date_item_t'{8'h20, 8'h2B, 8'h05, 8'h10});
    pending_dates.push_back(date_item_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    pending_dates.push_back(date_item_t'{8'h00, 8'h00, 8'h00, 8'h00});
    repeat (RANDOM_DATES) pending_dates.push_back(random_date());
    dates_total = pending_dates.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (dates_sent < dates_total || expected_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && unexpected == 0 && expected_flags.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_flags.push_back(date_exists({in_year_high_bcd, in_year_low_bcd,
                                              in_month_bcd, in_day_bcd}));
        dates_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          in_valid  <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_dates.size() != 0) begin
          {in_year_high_bcd, in_year_low_bcd, in_month_bcd, in_day_bcd}
            <= pending_dates.pop_front();
          in_valid  <= 1'b1;
          send_wait <= draw_wait(phase_cnt[8:7] == 2'd0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor, back-pressure and watchdog
  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1;
    if (!rst_n) begin
      out_ready    <= 1'b0;
      recv_stall   = 0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= REPORT_MAX)
            $display("%0t: result %0b with no date outstanding", $time, out_date_valid);
        end else begin
          want_flag = expected_flags.pop_front();
          if (out_date_valid !== want_flag) begin
            mismatches++;
            if (mismatches + unexpected <= REPORT_MAX)
              $display("%0t: date_valid expected %0b got %0b", $time, want_flag,
                       out_date_valid);
          end
        end
        recv_stall = draw_wait(phase_cnt[9:8] == 2'd1);
        out_ready <= (recv_stall == 0);
      end else if (!out_ready) begin
        if (recv_stall <= 1) out_ready <= 1'b1;
        recv_stall = recv_stall - 1;
      end

      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
